// ===== hdl/svpwm_voltage_modulator_macros.svh =====
// assertion macros for the svpwm voltage modulator
// used by the checker, expects aclk and aresetn in scope
`ifndef SVPWM_VOLTAGE_MODULATOR_MACROS_SVH
`define SVPWM_VOLTAGE_MODULATOR_MACROS_SVH

// clocked check, off while reset is asserted
`define SVPWM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// clocked check that also holds through reset
`define SVPWM_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== hdl/svpwm_pkg.sv =====
// shared types, constants and the sine table for the svpwm voltage modulator
// no dependencies
package svpwm_pkg;

    localparam int ANGLE_BITS_DEF = 16;
    localparam int VOLT_BITS_DEF  = 16;
    localparam int DIV_STEPS      = 16;

    // register map, one word per register
    typedef enum logic [2:0] {
        REG_ENABLE        = 3'd0,
        REG_POLE_PAIRS    = 3'd1,
        REG_ANGLE_OFFSET  = 3'd2,
        REG_VOLTAGE_LIMIT = 3'd3,
        REG_PWM_PERIOD    = 3'd4
    } reg_idx_t;

    localparam logic        ENABLE_RST        = 1'b0;
    localparam logic [6:0]  POLE_PAIRS_RST    = 7'd7;
    localparam logic [15:0] ANGLE_OFFSET_RST  = 16'd0;
    localparam logic [14:0] VOLTAGE_LIMIT_RST = 15'd16384;
    localparam logic [15:0] PWM_PERIOD_RST    = 16'd1000;

    // sqrt(3) scaled by 2^15
    localparam logic signed [17:0] SQRT3_Q15 = 18'sd56756;

    // quarter-wave sine, q15
    localparam logic [15:0] SINE_TABLE [0:32] = '{
        16'd0,     16'd1608,  16'd3212,  16'd4808,  16'd6393,  16'd7962,  16'd9512,
        16'd11039, 16'd12539, 16'd14010, 16'd15446, 16'd16846, 16'd18204, 16'd19519,
        16'd20787, 16'd22005, 16'd23170, 16'd24279, 16'd25329, 16'd26319, 16'd27245,
        16'd28105, 16'd28898, 16'd29621, 16'd30273, 16'd30852, 16'd31356, 16'd31785,
        16'd32137, 16'd32412, 16'd32609, 16'd32728, 16'd32767
    };

    // interpolated sine of a 16-bit phase, q15
    function automatic logic signed [15:0] sine_q15(input logic [15:0] ph);
        logic [1:0]  quad;
        logic [14:0] x;
        logic [5:0]  idx;
        logic [8:0]  frac;
        logic [15:0] base;
        logic [15:0] step;
        logic [24:0] prod;
        logic [15:0] s;
        quad = ph[15:14];
        x    = {1'b0, ph[13:0]};
        if (quad[0]) begin
            x = 15'd16384 - x;
        end
        idx  = x[14:9];
        frac = x[8:0];
        if (idx[5]) begin
            s = SINE_TABLE[32];
        end else begin
            base = SINE_TABLE[idx];
            step = SINE_TABLE[6'(idx) + 6'd1] - base;
            prod = 25'(step) * 25'(frac);
            s    = base + 16'(prod >> 9);
        end
        return quad[1] ? $signed(-s) : $signed(s);
    endfunction

endpackage

// ===== hdl/svpwm_voltage_modulator.sv =====
// svpwm voltage modulator top level: clamp, inverse park/clarke, min-max
// centering, duty scaling and a pipelined divider; uses svpwm_pkg
//
//  port group   | direction | handshake             | content
//  s_*          | in        | s_valid / s_ready     | vd, vq, mech_angle
//  m_*          | out       | m_valid / m_ready     | compare_a, compare_b, compare_c
//  apb          | in        | psel/penable/pwrite   | five config registers
//
// one beat accepted per cycle while the pipeline advances, through
// 26 register stages: 9 datapath, 16 restoring division by limit * 2^17, one output
// the whole pipeline holds when the output register is full and not taken
// aresetn clears valid bits and config registers, no clearing pass
module svpwm_voltage_modulator
    import svpwm_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF,
    parameter int VOLT_BITS  = VOLT_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_vd,
    input  logic signed [15:0] s_vq,
    input  logic [15:0]        s_mech_angle,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [15:0]        m_compare_a,
    output logic [15:0]        m_compare_b,
    output logic [15:0]        m_compare_c,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int VW  = ((VOLT_BITS > 16) ? VOLT_BITS : 16) + 1;
    localparam int XW  = 50;
    localparam int SW  = XW + 1;
    localparam int UW  = XW + 3;
    localparam int NST = 9 + DIV_STEPS + 1;

    // config registers
    logic        enable_reg;
    logic [6:0]  pole_pairs_reg;
    logic [15:0] angle_offset_reg;
    logic [14:0] voltage_limit_reg;
    logic [15:0] pwm_period_reg;
    logic        cfg_wr;
    reg_idx_t    cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = reg_idx_t'(paddr[4:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg        <= ENABLE_RST;
            pole_pairs_reg    <= POLE_PAIRS_RST;
            angle_offset_reg  <= ANGLE_OFFSET_RST;
            voltage_limit_reg <= VOLTAGE_LIMIT_RST;
            pwm_period_reg    <= PWM_PERIOD_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_ENABLE:        enable_reg        <= pwdata[0];
                REG_POLE_PAIRS:    pole_pairs_reg    <= pwdata[6:0];
                REG_ANGLE_OFFSET:  angle_offset_reg  <= pwdata[15:0];
                REG_VOLTAGE_LIMIT: voltage_limit_reg <= pwdata[14:0];
                REG_PWM_PERIOD:    pwm_period_reg    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (cfg_idx)
            REG_ENABLE:        prdata = {31'd0, enable_reg};
            REG_POLE_PAIRS:    prdata = {25'd0, pole_pairs_reg};
            REG_ANGLE_OFFSET:  prdata = {16'd0, angle_offset_reg};
            REG_VOLTAGE_LIMIT: prdata = {17'd0, voltage_limit_reg};
            REG_PWM_PERIOD:    prdata = {16'd0, pwm_period_reg};
            default:           prdata = 32'd0;
        endcase
    end

    // effective limit, zero acts as one
    logic [14:0] lim;
    assign lim = (voltage_limit_reg == 15'd0) ? 15'd1 : voltage_limit_reg;

    // pipeline advance and valid chain
    logic       advance;
    logic [NST:1] vld_reg;

    assign advance = m_ready | ~vld_reg[NST];
    assign s_ready = advance;
    assign m_valid = vld_reg[NST];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (advance) begin
            vld_reg <= {vld_reg[NST-1:1], s_valid};
        end
    end

    // stage 1: voltage clamp and electrical angle
    function automatic logic signed [15:0] clamp_volt(input logic signed [VW-1:0] v,
                                                      input logic [14:0] l);
        logic signed [VW-1:0] lw;
        logic signed [15:0]   r;
        lw = $signed(VW'(l));
        if (v > lw) begin
            r = $signed({1'b0, l});
        end else if (v < -lw) begin
            r = -$signed({1'b0, l});
        end else begin
            r = 16'(v);
        end
        return r;
    endfunction

    logic [VOLT_BITS-1:0]  vd_raw;
    logic [VOLT_BITS-1:0]  vq_raw;
    logic [ANGLE_BITS-1:0] mech_a;
    logic [ANGLE_BITS-1:0] elec_next;
    logic signed [15:0]    s1_vd_reg;
    logic signed [15:0]    s1_vq_reg;
    logic [ANGLE_BITS-1:0] s1_elec_reg;

    assign vd_raw    = VOLT_BITS'($unsigned(s_vd));
    assign vq_raw    = VOLT_BITS'($unsigned(s_vq));
    assign mech_a    = ANGLE_BITS'(s_mech_angle);
    assign elec_next = ANGLE_BITS'(mech_a * ANGLE_BITS'(pole_pairs_reg))
                       - ANGLE_BITS'(angle_offset_reg);

    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_vd_reg   <= clamp_volt(VW'($signed(vd_raw)), lim);
            s1_vq_reg   <= clamp_volt(VW'($signed(vq_raw)), lim);
            s1_elec_reg <= elec_next;
        end
    end

    // stage 2: sine and cosine lookup
    logic [ANGLE_BITS-1:0] cos_ang;
    logic [15:0]           ph_sin;
    logic [15:0]           ph_cos;
    logic signed [15:0]    s2_vd_reg;
    logic signed [15:0]    s2_vq_reg;
    logic signed [15:0]    s2_sn_reg;
    logic signed [15:0]    s2_cs_reg;

    assign cos_ang = s1_elec_reg + (ANGLE_BITS'(1) << (ANGLE_BITS - 2));
    assign ph_sin  = 16'({s1_elec_reg, 16'd0} >> ANGLE_BITS);
    assign ph_cos  = 16'({cos_ang, 16'd0} >> ANGLE_BITS);

    always_ff @(posedge aclk) begin
        if (advance) begin
            s2_vd_reg <= s1_vd_reg;
            s2_vq_reg <= s1_vq_reg;
            s2_sn_reg <= sine_q15(ph_sin);
            s2_cs_reg <= sine_q15(ph_cos);
        end
    end

    // stage 3: inverse park products
    logic signed [31:0] s3_pdc_reg;
    logic signed [31:0] s3_pqs_reg;
    logic signed [31:0] s3_pds_reg;
    logic signed [31:0] s3_pqc_reg;

    always_ff @(posedge aclk) begin
        if (advance) begin
            s3_pdc_reg <= s2_vd_reg * s2_cs_reg;
            s3_pqs_reg <= s2_vq_reg * s2_sn_reg;
            s3_pds_reg <= s2_vd_reg * s2_sn_reg;
            s3_pqc_reg <= s2_vq_reg * s2_cs_reg;
        end
    end

    // stage 4: alpha and beta
    logic signed [32:0] s4_alpha_reg;
    logic signed [32:0] s4_beta_reg;

    always_ff @(posedge aclk) begin
        if (advance) begin
            s4_alpha_reg <= 33'(s3_pdc_reg) - 33'(s3_pqs_reg);
            s4_beta_reg  <= 33'(s3_pds_reg) + 33'(s3_pqc_reg);
        end
    end

    // stage 5: inverse clarke terms
    logic signed [XW-1:0] bm_w;
    logic signed [XW-1:0] s5_x0_reg;
    logic signed [XW-1:0] s5_am_reg;
    logic signed [XW-1:0] s5_bm_reg;

    assign bm_w = s4_beta_reg * SQRT3_Q15;

    always_ff @(posedge aclk) begin
        if (advance) begin
            s5_x0_reg <= XW'(s4_alpha_reg) <<< 16;
            s5_am_reg <= XW'(s4_alpha_reg) <<< 15;
            s5_bm_reg <= bm_w;
        end
    end

    // stage 6: three phase voltages
    logic signed [XW-1:0] s6_x_reg [0:2];

    always_ff @(posedge aclk) begin
        if (advance) begin
            s6_x_reg[0] <= s5_x0_reg;
            s6_x_reg[1] <= s5_bm_reg - s5_am_reg;
            s6_x_reg[2] <= -s5_am_reg - s5_bm_reg;
        end
    end

    // stage 7: min plus max for centering
    logic signed [XW-1:0] mn01;
    logic signed [XW-1:0] mx01;
    logic signed [XW-1:0] mn_w;
    logic signed [XW-1:0] mx_w;
    logic signed [XW-1:0] s7_x_reg [0:2];
    logic signed [SW-1:0] s7_sum_reg;

    assign mn01 = (s6_x_reg[1] < s6_x_reg[0]) ? s6_x_reg[1] : s6_x_reg[0];
    assign mx01 = (s6_x_reg[1] > s6_x_reg[0]) ? s6_x_reg[1] : s6_x_reg[0];
    assign mn_w = (s6_x_reg[2] < mn01) ? s6_x_reg[2] : mn01;
    assign mx_w = (s6_x_reg[2] > mx01) ? s6_x_reg[2] : mx01;

    always_ff @(posedge aclk) begin
        if (advance) begin
            s7_x_reg   <= s6_x_reg;
            s7_sum_reg <= SW'(mn_w) + SW'(mx_w);
        end
    end

    // stage 8: offset by limit, clamp to 0..2*limit, drop low bits
    logic signed [UW-1:0] lim_sh;
    logic signed [UW-1:0] lim_full;
    logic [31:0]          num_next [0:2];
    logic [31:0]          s8_num_reg [0:2];

    assign lim_sh   = $signed(UW'({lim, 32'd0}));
    assign lim_full = $signed(UW'({lim, 33'd0}));

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            logic signed [UW-1:0] n;
            n = (UW'(s7_x_reg[i]) <<< 1) - UW'(s7_sum_reg) + lim_sh;
            if (n < 0) begin
                n = '0;
            end else if (n > lim_full) begin
                n = lim_full;
            end
            num_next[i] = n[47:16];
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s8_num_reg <= num_next;
        end
    end

    // stage 9 and divider: numerator times period, then divide by limit * 2^17
    logic [47:0] div_den;
    logic [47:0] div_rem_reg  [0:DIV_STEPS][0:2];
    logic [15:0] div_quo_reg  [0:DIV_STEPS][0:2];
    logic [47:0] div_rem_next [1:DIV_STEPS][0:2];
    logic [15:0] div_quo_next [1:DIV_STEPS][0:2];

    assign div_den = 48'({lim, 17'd0});

    // one quotient bit per stage, most significant first
    always_comb begin
        for (int j = 0; j < DIV_STEPS; j++) begin
            for (int i = 0; i < 3; i++) begin
                logic [47:0] dsh;
                logic        ge;
                dsh = div_den << (DIV_STEPS - 1 - j);
                ge  = (div_rem_reg[j][i] >= dsh);
                div_rem_next[j+1][i] = ge ? (div_rem_reg[j][i] - dsh) : div_rem_reg[j][i];
                div_quo_next[j+1][i] = {div_quo_reg[j][i][14:0], ge};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int i = 0; i < 3; i++) begin
                div_rem_reg[0][i] <= 48'(s8_num_reg[i]) * 48'(pwm_period_reg);
                div_quo_reg[0][i] <= '0;
            end
            for (int j = 1; j <= DIV_STEPS; j++) begin
                div_rem_reg[j] <= div_rem_next[j];
                div_quo_reg[j] <= div_quo_next[j];
            end
        end
    end

    // output register, half period when modulation is off
    logic [15:0] half_period;
    logic [15:0] cmp_a_reg;
    logic [15:0] cmp_b_reg;
    logic [15:0] cmp_c_reg;

    assign half_period = pwm_period_reg >> 1;

    always_ff @(posedge aclk) begin
        if (advance) begin
            cmp_a_reg <= enable_reg ? div_quo_reg[DIV_STEPS][0] : half_period;
            cmp_b_reg <= enable_reg ? div_quo_reg[DIV_STEPS][1] : half_period;
            cmp_c_reg <= enable_reg ? div_quo_reg[DIV_STEPS][2] : half_period;
        end
    end

    assign m_compare_a = cmp_a_reg;
    assign m_compare_b = cmp_b_reg;
    assign m_compare_c = cmp_c_reg;

endmodule

// ===== hdl/svpwm_checker.sv =====
// port-level checks for the svpwm voltage modulator, bound to the top level
// depends on svpwm_voltage_modulator_macros.svh
`include "svpwm_voltage_modulator_macros.svh"

module svpwm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [15:0] m_compare_a,
    input logic [15:0] m_compare_b,
    input logic [15:0] m_compare_c,
    input logic        pready
);

    // a stalled result beat holds its values
    `SVPWM_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_compare_a) && $stable(m_compare_b) && $stable(m_compare_c), "result beat changed while stalled")

    // an empty output register never blocks the input
    `SVPWM_ASSERT(a_in_open, !m_valid |-> s_ready, "input stalled with empty output")

    // reset empties the pipeline
    `SVPWM_ASSERT_RST(a_rst_empty, !aresetn |=> !m_valid, "result valid right after reset")

    // config port never waits
    `SVPWM_ASSERT(a_pready, pready, "pready dropped")

endmodule

bind svpwm_voltage_modulator svpwm_checker u_svpwm_checker (.*);

// ===== verif/svpwm_voltage_modulator_test.sv =====
// self-checking testbench for the svpwm voltage modulator
// depends on svpwm_pkg and the svpwm_voltage_modulator rtl, nothing else
`timescale 1ns / 100ps

module svpwm_voltage_modulator_test;
    import svpwm_pkg::*;

    localparam int LATENCY    = 26;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic signed [15:0] vd;
        logic signed [15:0] vq;
        logic [15:0]        mech_angle;
    } drive_beat_t;

    typedef struct packed {
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] c;
    } compare_set_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [15:0] s_vd = '0;
    logic signed [15:0] s_vq = '0;
    logic [15:0] s_mech_angle = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [15:0] m_compare_a, m_compare_b, m_compare_c;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [4:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    // configuration mirror used by the predictor
    logic        cfg_enable;
    logic [6:0]  cfg_pole_pairs;
    logic [15:0] cfg_angle_offset;
    logic [14:0] cfg_voltage_limit;
    logic [15:0] cfg_pwm_period;

    drive_beat_t  pending_beats[$];
    compare_set_t expected_compares[$];
    int mismatch_count = 0;
    int result_count = 0;
    int quiet_cycles = 0;
    bit idle_free = 1'b0;

    svpwm_voltage_modulator uut (.*);

    always #2 aclk = ~aclk;

    // quarter-wave interpolated sine, q15
    function automatic longint sine_of(input logic [15:0] ph);
        int quarter_tab [0:32] = '{0, 1608, 3212, 4808, 6393, 7962, 9512, 11039,
            12539, 14010, 15446, 16846, 18204, 19519, 20787, 22005, 23170, 24279,
            25329, 26319, 27245, 28105, 28898, 29621, 30273, 30852, 31356, 31785,
            32137, 32412, 32609, 32728, 32767};
        int x, idx, frac;
        longint s;
        x = ph[13:0];
        if (ph[14]) x = 16384 - x;
        idx = x >> 9;
        frac = x & 511;
        if (idx >= 32) s = quarter_tab[32];
        else s = quarter_tab[idx] + (((quarter_tab[idx+1] - quarter_tab[idx]) * frac) >> 9);
        return ph[15] ? -s : s;
    endfunction

    function automatic longint clamp_volt(input logic signed [15:0] v, input longint lim);
        longint s;
        s = v;
        if (s > lim) s = lim;
        if (s < -lim) s = -lim;
        return s;
    endfunction

    function automatic logic [15:0] duty_compare(input longint u4, input longint lim);
        longint n, full;
        longint unsigned q;
        n = lim * (64'sd1 <<< 32) + u4;
        full = lim * (64'sd1 <<< 33);
        if (n < 0) n = 0;
        if (n > full) n = full;
        q = ((unsigned'(n) >> 16) * cfg_pwm_period) / (unsigned'(lim) << 17);
        return q[15:0];
    endfunction

    // expected compare values for one beat under the current registers
    function automatic compare_set_t predict_compares(input drive_beat_t b);
        compare_set_t r;
        longint lim, vd, vq, sn, cs, alpha, beta, mn, mx;
        longint x[3];
        logic [15:0] elec;
        if (!cfg_enable) begin
            r.a = cfg_pwm_period >> 1;
            r.b = r.a;
            r.c = r.a;
            return r;
        end
        lim = (cfg_voltage_limit == 0) ? 1 : cfg_voltage_limit;
        vd = clamp_volt(b.vd, lim);
        vq = clamp_volt(b.vq, lim);
        elec = 16'(b.mech_angle * cfg_pole_pairs - cfg_angle_offset);
        sn = sine_of(elec);
        cs = sine_of(16'(elec + 16'h4000));
        alpha = vd * cs - vq * sn;
        beta = vd * sn + vq * cs;
        x[0] = alpha * 65536;
        x[1] = -alpha * 32768 + beta * 56756;
        x[2] = -alpha * 32768 - beta * 56756;
        mn = x[0];
        mx = x[0];
        for (int i = 1; i < 3; i++) begin
            if (x[i] < mn) mn = x[i];
            if (x[i] > mx) mx = x[i];
        end
        r.a = duty_compare(2 * x[0] - (mn + mx), lim);
        r.b = duty_compare(2 * x[1] - (mn + mx), lim);
        r.c = duty_compare(2 * x[2] - (mn + mx), lim);
        return r;
    endfunction

    // input driver, valid held until accepted
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) expected_compares.push_back(predict_compares({s_vd, s_vq, s_mech_angle}));
            if (pending_beats.size() > 0 && (idle_free || $urandom_range(99) >= 28)) begin
                drive_beat_t b;
                b = pending_beats.pop_front();
                s_vd <= b.vd;
                s_vq <= b.vq;
                s_mech_angle <= b.mech_angle;
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result monitor and random back pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= idle_free || ($urandom_range(99) >= 28);
            if (m_valid && m_ready) begin
                result_count++;
                if (expected_compares.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) $display("unexpected result beat a=%0d b=%0d c=%0d",
                        m_compare_a, m_compare_b, m_compare_c);
                end else begin
                    compare_set_t e;
                    e = expected_compares.pop_front();
                    if (e != {m_compare_a, m_compare_b, m_compare_c}) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: exp a=%0d b=%0d c=%0d got a=%0d b=%0d c=%0d",
                                e.a, e.b, e.c, m_compare_a, m_compare_b, m_compare_c);
                    end
                end
            end
        end
    end

    // watchdog on cycles without any accepted beat or config access
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || psel) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT) begin
            $display("** svpwm_voltage_modulator: FAILED **");
            $finish;
        end
    end

    task automatic reg_write(input reg_idx_t idx, input logic [31:0] val);
        @(posedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 5'(idx) << 2;
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_ENABLE:        cfg_enable = val[0];
            REG_POLE_PAIRS:    cfg_pole_pairs = val[6:0];
            REG_ANGLE_OFFSET:  cfg_angle_offset = val[15:0];
            REG_VOLTAGE_LIMIT: cfg_voltage_limit = val[14:0];
            REG_PWM_PERIOD:    cfg_pwm_period = val[15:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic en, input logic [6:0] pp, input logic [15:0] off,
                              input logic [14:0] lim, input logic [15:0] per);
        reg_write(REG_ENABLE, 32'(en));
        reg_write(REG_POLE_PAIRS, 32'(pp));
        reg_write(REG_ANGLE_OFFSET, 32'(off));
        reg_write(REG_VOLTAGE_LIMIT, 32'(lim));
        reg_write(REG_PWM_PERIOD, 32'(per));
    endtask

    // wait until queued beats are sent and all results are back
    task automatic drain();
        while (pending_beats.size() > 0 || s_valid || expected_compares.size() > 0)
            @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    task automatic push_beat(input logic [15:0] vd, input logic [15:0] vq, input logic [15:0] ang);
        drive_beat_t b;
        b.vd = vd;
        b.vq = vq;
        b.mech_angle = ang;
        pending_beats.push_back(b);
    endtask

    task automatic push_random(input int n);
        repeat (n) push_beat(16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    initial begin
        cfg_enable = ENABLE_RST;
        cfg_pole_pairs = POLE_PAIRS_RST;
        cfg_angle_offset = ANGLE_OFFSET_RST;
        cfg_voltage_limit = VOLTAGE_LIMIT_RST;
        cfg_pwm_period = PWM_PERIOD_RST;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // disabled after reset: half period everywhere
        push_beat(16'h7fff, 16'h8000, 16'hffff);
        push_beat(16'h1234, 16'h0000, 16'h0000);
        drain();

        // directed: field extremes, quadrant edges, clamping
        set_config(1'b1, 7'd1, 16'd0, 15'd16384, 16'd1000);
        push_beat(16'h0000, 16'h0000, 16'h0000);
        push_beat(16'h7fff, 16'h0000, 16'h0000);
        push_beat(16'h8000, 16'h0000, 16'h4000);
        push_beat(16'h0000, 16'h7fff, 16'h8000);
        push_beat(16'h0000, 16'h8000, 16'hc000);
        push_beat(16'h4000, 16'h4000, 16'hffff);
        push_beat(16'hc000, 16'h3fff, 16'h2000);
        push_beat(16'h5555, 16'haaaa, 16'h5555);
        push_beat(16'haaaa, 16'h5555, 16'haaaa);
        push_beat(16'h0001, 16'hffff, 16'h0001);
        drain();

        // zero limit, zero period, zero pole pairs, then limit one, 127 pole pairs, full period
        set_config(1'b1, 7'd0, 16'hffff, 15'd0, 16'd0);
        push_random(5);
        drain();
        set_config(1'b1, 7'd127, 16'h1234, 15'd1, 16'hffff);
        push_beat(16'h7fff, 16'h8000, 16'hffff);
        push_random(5);
        drain();

        // random phases under several settings, one with no idling
        for (int ph = 0; ph < 6; ph++) begin
            idle_free = (ph == 3);
            if (ph == 5) begin
                set_config(1'b1, 7'd64, 16'hffff, 15'h7fff, 16'hffff);
            end else begin
                set_config(1'b1, 7'($urandom_range(1, 64)), 16'($urandom),
                           15'($urandom_range(1, 32767)), 16'($urandom_range(1, 65535)));
            end
            push_random(60);
            drain();
        end
        idle_free = 1'b0;
        set_config(1'b0, 7'd7, 16'd0, 15'd16384, 16'd999);
        push_random(20);
        drain();

        $display("covered %0d result beats over reset, extreme and random register settings",
                 result_count);
        $display("including zero limit, zero period, disabled mode and no-idle stretches");
        if (mismatch_count == 0 && expected_compares.size() == 0) begin
            $display("** svpwm_voltage_modulator: PASSED **");
        end else begin
            $display("** svpwm_voltage_modulator: FAILED **");
        end
        $finish;
    end
endmodule

// ===== svpwm_voltage_modulator.f =====
+incdir+hdl
hdl/svpwm_pkg.sv
hdl/svpwm_voltage_modulator.sv
hdl/svpwm_checker.sv
verif/svpwm_voltage_modulator_test.sv
